// ----- rtl/core/sorted_value_table_defines.svh -----
// Assertion macros for the sorted value table checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SORTED_VALUE_TABLE_DEFINES_SVH
`define SORTED_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/svt_pkg.sv -----
// Package for the sorted value table: command and result types, codes, defaults.
// No dependencies.
`default_nettype none

package svt_pkg;

  localparam int unsigned SVT_DEPTH = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_LAST,
    S_REM_WALK,
    S_RD_WAIT
  } state_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] value;
    logic [5:0]         index;
  } svt_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } svt_rsp_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } svt_cmp_t;

endpackage

`default_nettype wire

// ----- rtl/core/svt_cmp.sv -----
// Shared signed comparator for the sorted value table walk.
// Depends on svt_pkg.
`default_nettype none

module svt_cmp (
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output svt_pkg::svt_cmp_t       res_o
);
  import svt_pkg::*;

  always_comb begin
    res_o.gt = (a_i > b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_value_table.sv -----
// Sorted value table top level: sequencer, entry memory and shared comparator.
// Depends on svt_pkg and svt_cmp.
//
// Holds up to DEPTH signed values in ascending order in a memory with one write
// port and one registered read port. A command is taken when start is high and
// busy is low; its result appears on rsp_o for exactly one cycle with done_o high
// and cannot be held off, so the receiver must take it in that cycle. Full-table
// inserts, inserts into an empty table, removes on an empty table, out-of-range
// reads and the unused action code answer the cycle after the command. A read waits
// in S_RD_WAIT for the registered read port and then answers. Any other insert walks
// down from the top entry, moving one entry per cycle through the comparator: it
// shifts up each stored entry greater than the value, writes the value into the gap
// (through S_INS_LAST when it lands in entry 0), and answers the cycle after that. A
// remove compacts the table in one pass over the stored entries, and answers the
// cycle after. The memory's one read and one write per cycle set this pace.
`default_nettype none

module sorted_value_table #(
  parameter int unsigned DEPTH = svt_pkg::SVT_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire svt_pkg::svt_req_t req_i,
  output svt_pkg::svt_rsp_t  rsp_o,
  output logic               done_o
);
  import svt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = 6;
  localparam int unsigned XW = (CW > IW) ? CW : IW;

  state_e             state_q, state_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      wr_q, wr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  svt_rsp_t           rsp_q, rsp_d;
  logic               done_q, done_d;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;

  svt_cmp_t           cmp;
  logic               full;
  logic               empty;
  logic               idx_ok;
  logic               walk_last;

  svt_cmp u_cmp (
    .a_i   (rdata_q),
    .b_i   (val_q),
    .res_o (cmp)
  );

  assign full      = (cnt_q == CW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign idx_ok    = (XW'(req_i.index) < XW'(cnt_q));
  assign walk_last = (ptr_q == cnt_q - CW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.action)
            ACT_INSERT: if (!full && !empty) state_d = S_INS_WALK;
            ACT_REMOVE: if (!empty) state_d = S_REM_WALK;
            ACT_READ:   if (idx_ok) state_d = S_RD_WAIT;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_INS_WALK: begin
        if (!cmp.gt) begin
          state_d = S_IDLE;
        end else if (ptr_q == CW'(1)) begin
          state_d = S_INS_LAST;
        end
      end
      S_INS_LAST: state_d = S_IDLE;
      S_REM_WALK: if (walk_last) state_d = S_IDLE;
      S_RD_WAIT:  state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = '0;
    wdata  = val_q;
    raddr  = '0;
    val_d  = val_q;
    ptr_d  = ptr_q;
    wr_d   = wr_q;
    cnt_d  = cnt_q;
    rsp_d  = rsp_q;
    done_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d = req_i.value;
          rsp_d.read_value = '0;
          rsp_d.status     = ST_OK;
          case (req_i.action)
            ACT_INSERT: begin
              if (full) begin
                rsp_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (empty) begin
                mem_we = 1'b1;
                wdata  = req_i.value;
                cnt_d  = cnt_q + CW'(1);
                done_d = 1'b1;
              end else begin
                ptr_d = cnt_q;
                raddr = AW'(cnt_q - CW'(1));
              end
            end
            ACT_REMOVE: begin
              if (empty) begin
                rsp_d.status = ST_NOT_FOUND;
                done_d       = 1'b1;
              end else begin
                ptr_d = '0;
                wr_d  = '0;
              end
            end
            ACT_READ: begin
              if (idx_ok) begin
                raddr = AW'(req_i.index);
              end else begin
                rsp_d.status = ST_BAD_INDEX;
                done_d       = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_INS_WALK: begin
        mem_we = 1'b1;
        waddr  = AW'(ptr_q);
        if (cmp.gt) begin
          wdata = rdata_q;
          ptr_d = ptr_q - CW'(1);
          raddr = AW'(ptr_q - CW'(2));
        end else begin
          cnt_d  = cnt_q + CW'(1);
          done_d = 1'b1;
        end
      end
      S_INS_LAST: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        done_d = 1'b1;
      end
      S_REM_WALK: begin
        if (!cmp.eq) begin
          mem_we = 1'b1;
          waddr  = AW'(wr_q);
          wdata  = rdata_q;
          wr_d   = wr_q + CW'(1);
        end
        ptr_d = ptr_q + CW'(1);
        raddr = AW'(ptr_q + CW'(1));
        if (walk_last) begin
          done_d = 1'b1;
          if (wr_d == cnt_q) begin
            rsp_d.status = ST_NOT_FOUND;
          end else begin
            cnt_d = wr_d;
          end
        end
      end
      S_RD_WAIT: begin
        rsp_d.read_value = rdata_q;
        done_d           = 1'b1;
      end
      default: done_d = 1'b0;
    endcase
    rsp_d.entry_count = 7'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    ptr_q <= ptr_d;
    wr_q  <= wr_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign busy   = (state_q != S_IDLE);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/svt_checker.sv -----
// Port-level checks for the sorted value table, bound to the top level.
// Depends on svt_pkg and sorted_value_table_defines.svh.
`default_nettype none

`include "sorted_value_table_defines.svh"

module svt_checker #(
  parameter int unsigned DEPTH = svt_pkg::SVT_DEPTH
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire svt_pkg::svt_rsp_t rsp_o,
  input wire logic              done_o
);
  import svt_pkg::*;

  `SVT_ASSERT_NEXT(a_accept_answers, start && !busy, busy || done_o, "command neither walked nor answered")
  `SVT_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while still busy")
  `SVT_ASSERT_NOW(a_full_count, done_o && rsp_o.status == ST_FULL, rsp_o.entry_count == 7'(DEPTH), "full reported below depth")
  `SVT_ASSERT_NOW(a_zero_value, done_o && rsp_o.status != ST_OK, rsp_o.read_value == 32'sd0, "error result carries data")

endmodule

bind sorted_value_table svt_checker #(.DEPTH(DEPTH)) u_svt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .rsp_o  (rsp_o),
  .done_o (done_o)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for sorted_value_table: directed table then random command mix.
// Every result is checked against a typed expected result or an in-bench shadow of the sorted table.
// Depends on svt_pkg and the sorted_value_table RTL.
`timescale 1ns / 1ps

module tb;
  import svt_pkg::*;

  localparam logic [1:0] ACT_SPARE    = 2'd3;
  localparam int         RANDOM_ITEMS = 1825;
  localparam int         TAIL_CYCLES  = 80;
  localparam int         REPORT_LIMIT = 10;

  typedef struct {
    svt_req_t req;
    bit       typed;
    svt_rsp_t rsp;
  } cmd_row_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  svt_req_t req_i  = '0;
  logic     busy;
  svt_rsp_t rsp_o;
  logic     done_o;

  logic signed [31:0] shadow_entries [SVT_DEPTH];
  int                 shadow_count = 0;
  svt_rsp_t           expected_rsp_q [$];
  svt_rsp_t           want_rsp;
  cmd_row_t           directed_rows [25];

  int mismatches = 0;
  int checked    = 0;
  int n_insert   = 0;
  int n_remove   = 0;
  int n_read     = 0;
  int n_spare    = 0;
  int n_full     = 0;
  int n_miss     = 0;
  int n_bad_idx  = 0;
  int peak_count = 0;

  sorted_value_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one command to the shadow table and return the result it must produce.
  function automatic svt_rsp_t table_apply(svt_req_t r);
    svt_rsp_t o;
    int       pos;
    int       keep;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_INSERT: begin
        if (shadow_count >= SVT_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_entries[pos] < r.value) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = r.value;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        keep = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] != r.value) begin
            shadow_entries[keep] = shadow_entries[i];
            keep++;
          end
        end
        if (keep == shadow_count) o.status = ST_NOT_FOUND;
        else shadow_count = keep;
      end
      ACT_READ: begin
        if (int'(r.index) < shadow_count) o.read_value = shadow_entries[r.index];
        else o.status = ST_BAD_INDEX;
      end
      default: ;
    endcase
    o.entry_count = shadow_count[6:0];
    return o;
  endfunction

  function automatic logic signed [31:0] pick_value(int stored_bias);
    int sel;
    sel = $urandom_range(0, 99);
    if (shadow_count > 0 && sel < stored_bias)
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom;
    if (sel < 75) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0001;
      3: return 32'sh7FFF_FFFE;
      4: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic svt_req_t draw_command(int mode);
    svt_req_t r;
    int       sel;
    int       cut_ins;
    int       cut_rem;
    int       cut_rd;
    sel = $urandom_range(0, 99);
    case (mode)
      0: begin cut_ins = 85; cut_rem = 90; cut_rd = 97; end
      1: begin cut_ins = 15; cut_rem = 85; cut_rd = 97; end
      2: begin cut_ins = 40; cut_rem = 68; cut_rd = 95; end
      default: begin cut_ins = 25; cut_rem = 40; cut_rd = 97; end
    endcase
    r.index = 6'($urandom_range(0, 63));
    if (sel < cut_ins) begin
      r.action = ACT_INSERT;
      r.value  = pick_value(15);
    end else if (sel < cut_rem) begin
      r.action = ACT_REMOVE;
      r.value  = pick_value(70);
    end else if (sel < cut_rd) begin
      r.action = ACT_READ;
      r.value  = $urandom;
      if (shadow_count > 0 && $urandom_range(0, 4) != 0)
        r.index = 6'($urandom_range(0, shadow_count - 1));
    end else begin
      r.action = action_e'(ACT_SPARE);
      r.value  = $urandom;
    end
    return r;
  endfunction

  // Drive one transaction, hold it until taken, then record its expected result.
  task automatic issue(input svt_req_t r, input bit typed, input svt_rsp_t typed_rsp,
                       input int gap);
    svt_rsp_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = table_apply(r);
    expected_rsp_q.push_back(typed ? typed_rsp : pred);
    case (r.action)
      ACT_INSERT: n_insert++;
      ACT_REMOVE: n_remove++;
      ACT_READ:   n_read++;
      default:    n_spare++;
    endcase
    case (pred.status)
      ST_FULL:      n_full++;
      ST_NOT_FOUND: n_miss++;
      ST_BAD_INDEX: n_bad_idx++;
      default: ;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      checked++;
      if (expected_rsp_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d value %0d count %0d",
                                rsp_o.status, rsp_o.read_value, rsp_o.entry_count));
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        if (rsp_o.status !== want_rsp.status || rsp_o.read_value !== want_rsp.read_value ||
            rsp_o.entry_count !== want_rsp.entry_count) begin
          note_mismatch($sformatf(
            "status exp %0d got %0d, value exp %0d got %0d, count exp %0d got %0d",
            want_rsp.status, rsp_o.status, want_rsp.read_value, rsp_o.read_value,
            want_rsp.entry_count, rsp_o.entry_count));
        end
      end
    end
  end

  initial begin
    int issued;
    int mode;
    int seg_len;
    bit calm;

    directed_rows[0]  = '{'{ACT_READ,   32'sd0,  6'd0},  1'b1, '{ST_BAD_INDEX, 32'sd0, 7'd0}};
    directed_rows[1]  = '{'{ACT_REMOVE, 32'sd5,  6'd0},  1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0}};
    directed_rows[2]  = '{'{action_e'(ACT_SPARE), 32'sd7, 6'd9}, 1'b1,
                          '{ST_OK, 32'sd0, 7'd0}};
    directed_rows[3]  = '{'{ACT_INSERT, 32'sh8000_0000, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 7'd1}};
    directed_rows[4]  = '{'{ACT_INSERT, 32'sh7FFF_FFFF, 6'd0}, 1'b1, '{ST_OK, 32'sd0, 7'd2}};
    directed_rows[5]  = '{'{ACT_INSERT, 32'sd0,  6'd0},  1'b1, '{ST_OK, 32'sd0, 7'd3}};
    directed_rows[6]  = '{'{ACT_INSERT, -32'sd1, 6'd0},  1'b1, '{ST_OK, 32'sd0, 7'd4}};
    directed_rows[7]  = '{'{ACT_INSERT, 32'sd0,  6'd0},  1'b1, '{ST_OK, 32'sd0, 7'd5}};
    directed_rows[8]  = '{'{ACT_INSERT, -32'sd1, 6'd0},  1'b1, '{ST_OK, 32'sd0, 7'd6}};
    directed_rows[9]  = '{'{ACT_READ,   32'sd0,  6'd0},  1'b1,
                          '{ST_OK, 32'sh8000_0000, 7'd6}};
    directed_rows[10] = '{'{ACT_READ,   32'sd0,  6'd5},  1'b1,
                          '{ST_OK, 32'sh7FFF_FFFF, 7'd6}};
    directed_rows[11] = '{'{ACT_READ,   32'sd0,  6'd2},  1'b0, '0};
    directed_rows[12] = '{'{ACT_READ,   32'sd0,  6'd3},  1'b0, '0};
    directed_rows[13] = '{'{ACT_READ,   32'sd0,  6'd6},  1'b1, '{ST_BAD_INDEX, 32'sd0, 7'd6}};
    directed_rows[14] = '{'{ACT_READ,   -32'sd1, 6'd63}, 1'b1, '{ST_BAD_INDEX, 32'sd0, 7'd6}};
    directed_rows[15] = '{'{ACT_REMOVE, 32'sd0,  6'd0},  1'b1, '{ST_OK, 32'sd0, 7'd4}};
    directed_rows[16] = '{'{ACT_REMOVE, 32'sd0,  6'd0},  1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd4}};
    directed_rows[17] = '{'{action_e'(ACT_SPARE), -32'sd1, 6'd63}, 1'b1,
                          '{ST_OK, 32'sd0, 7'd4}};
    directed_rows[18] = '{'{ACT_INSERT, 32'sh5555_5555, 6'd0}, 1'b0, '0};
    directed_rows[19] = '{'{ACT_INSERT, 32'shAAAA_AAAA, 6'd0}, 1'b0, '0};
    directed_rows[20] = '{'{ACT_READ,   32'sd0,  6'd1},  1'b0, '0};
    directed_rows[21] = '{'{ACT_REMOVE, 32'sh8000_0000, 6'd0}, 1'b0, '0};
    directed_rows[22] = '{'{ACT_REMOVE, 32'sh7FFF_FFFF, 6'd0}, 1'b0, '0};
    directed_rows[23] = '{'{ACT_REMOVE, -32'sd1, 6'd0},  1'b0, '0};
    directed_rows[24] = '{'{ACT_READ,   32'sd0,  6'd0},  1'b0, '0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp,
            $urandom_range(0, 17));
    settle();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(30, 90);
      calm    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) settle();
      repeat (seg_len) begin
        issue(draw_command(mode), 1'b0, '0, calm ? 0 : $urandom_range(0, 17));
        issued++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped on full), %0d removes (%0d missed),",
             n_insert, n_full, n_remove, n_miss);
    $display("%0d reads (%0d out of range), %0d spare codes; %0d results, peak fill %0d",
             n_read, n_bad_idx, n_spare, checked, peak_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_rsp_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
